/* rtl/dbhm_pkg.sv */
// Shared constants, register codes and types for the dual-bank holdoff monitor.
package dbhm_pkg;

    localparam int SCORE_BITS = 16;
    localparam int TIME_BITS  = 24;
    localparam int SEV_W      = 16;
    localparam int DT_W       = 16;
    localparam int TAU_W      = 24;
    localparam int CFG_W      = 24;
    localparam int IDX_W      = 3;
    localparam int NUM_W      = SCORE_BITS + DT_W + 1;
    localparam int CNT_W      = $clog2(SCORE_BITS + 1);
    localparam int IN_W       = 80;
    localparam int OUT_W      = 88;

    localparam logic [IDX_W-1:0] REG_HOLDOFF = 3'd0;
    localparam logic [IDX_W-1:0] REG_RELEASE = 3'd1;
    localparam logic [IDX_W-1:0] REG_RISE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DECAY   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DWELL   = 3'd4;

    localparam logic [15:0]      HOLDOFF_RST = 16'd32768;
    localparam logic [15:0]      RELEASE_RST = 16'd16384;
    localparam logic [TAU_W-1:0] RISE_RST    = 24'd50000;
    localparam logic [TAU_W-1:0] DECAY_RST   = 24'd200000;
    localparam logic [TAU_W-1:0] DWELL_RST   = 24'd100000;

    typedef struct packed {
        logic [15:0]      holdoff_threshold;
        logic [15:0]      release_threshold;
        logic [TAU_W-1:0] rise_tau_us;
        logic [TAU_W-1:0] decay_tau_us;
        logic [TAU_W-1:0] dwell_us;
    } cfg_t;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic                  recovering;
        logic [TIME_BITS-1:0]  timer;
    } lane_res_t;

endpackage

/* rtl/dbhm_div.sv */
// Restoring divider that produces one quotient bit per cycle for the blend step.
module dbhm_div
    import dbhm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_W-1:0]      num,
    input  logic [TAU_W-1:0]      den,
    output logic                  done,
    output logic [SCORE_BITS-1:0] quo
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TAU_W-1:0]      rem_reg, rem_next;
    logic [SCORE_BITS-1:0] lo_reg, lo_next;
    logic [SCORE_BITS-1:0] quo_reg, quo_next;
    logic [TAU_W:0]        trial;
    logic                  qbit;

    always_comb
    begin
        trial     = {rem_reg, lo_reg[SCORE_BITS-1]};
        qbit      = (trial >= {1'b0, den});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // The quotient is known to fit in SCORE_BITS, so the upper numerator
            // bits already form a remainder below the divisor.
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SCORE_BITS);
            rem_next  = TAU_W'(num[NUM_W-1:SCORE_BITS]);
            lo_next   = num[SCORE_BITS-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? TAU_W'(trial - {1'b0, den}) : TAU_W'(trial);
            lo_next  = {lo_reg[SCORE_BITS-2:0], 1'b0};
            quo_next = {quo_reg[SCORE_BITS-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/dbhm_lane.sv */
// One bank: severity select, score blend, dwell timer and recovery flag.
module dbhm_lane
    import dbhm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SEV_W-1:0] anomaly,
    input  logic [SEV_W-1:0] memory_level,
    input  logic [DT_W-1:0] dt_us,
    input  cfg_t            cfg,
    output logic            done,
    output lane_res_t       res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [SCORE_BITS-1:0] score_reg, score_next;
    logic                  rec_reg, rec_next;
    logic [TIME_BITS-1:0]  timer_reg, timer_next;
    logic                  done_reg, done_next;

    logic [SCORE_BITS-1:0] target_reg, diff_reg;
    logic [DT_W-1:0]       dt_reg;
    logic [TAU_W-1:0]      tau_reg;
    logic                  trig_reg, up_reg, hold_reg, full_reg;

    logic [SCORE_BITS-1:0] sev, target, diff, step;
    logic [TAU_W-1:0]      tau;
    logic                  trig, up;
    logic [NUM_W-1:0]      diff_ext, dt_ext, num;
    logic                  div_start, div_done;
    logic [SCORE_BITS-1:0] quo;
    logic [TIME_BITS-1:0]  dt_time, timer_dec;

    always_comb
    begin
        sev      = (anomaly > memory_level) ? SCORE_BITS'(anomaly) : SCORE_BITS'(memory_level);
        trig     = (sev >= SCORE_BITS'(cfg.holdoff_threshold));
        target   = trig ? sev : '0;
        tau      = trig ? cfg.rise_tau_us : cfg.decay_tau_us;
        up       = (target >= score_reg);
        diff     = up ? (target - score_reg) : (score_reg - target);
        diff_ext = NUM_W'(diff_reg);
        dt_ext   = NUM_W'(dt_reg);
        num      = (diff_ext * dt_ext) + NUM_W'(tau_reg >> 1);
        div_start = (state_reg == ST_MUL);
        step     = (quo > diff_reg) ? diff_reg : quo;
        dt_time  = TIME_BITS'(dt_reg);
        timer_dec = (timer_reg > dt_time) ? (timer_reg - dt_time) : '0;
    end

    dbhm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (tau_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        score_next = score_reg;
        rec_next   = rec_reg;
        timer_next = timer_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (hold_reg)
                        score_next = score_reg;
                    else if (full_reg)
                        score_next = target_reg;
                    else if (up_reg)
                        score_next = score_reg + step;
                    else
                        score_next = score_reg - step;
                    if (trig_reg)
                    begin
                        rec_next   = 1'b1;
                        timer_next = TIME_BITS'(cfg.dwell_us);
                    end
                    else
                    begin
                        if (dt_reg != '0)
                            timer_next = timer_dec;
                        if ((timer_next == '0) &&
                            (score_next <= SCORE_BITS'(cfg.release_threshold)))
                            rec_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            score_reg <= '0;
            rec_reg   <= 1'b0;
            timer_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            score_reg <= score_next;
            rec_reg   <= rec_next;
            timer_reg <= timer_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            target_reg <= target;
            diff_reg   <= diff;
            dt_reg     <= dt_us;
            tau_reg    <= tau;
            trig_reg   <= trig;
            up_reg     <= up;
            hold_reg   <= (dt_us == '0) || (tau == '0);
            full_reg   <= (TAU_W'(dt_us) >= tau);
        end
    end

    assign done           = done_reg;
    assign res.score      = score_reg;
    assign res.recovering = rec_reg;
    assign res.timer      = timer_reg;

endmodule

/* rtl/dual_bank_holdoff_monitor_unit.sv */
// Top level: configuration registers, two bank lanes and the merging output stage.
//
//  channel  direction  handshake           payload
//  s        in         s_tvalid/s_tready   s_tdata: four severities and dt_us
//  m        out        m_tvalid/m_tready   m_tdata: scores, flags and timers
//  cfg      in         cfg_we              cfg_index, cfg_data
//
// From its transfer to a valid result, a tick passes through the multiply step, the bit-serial
// divider in each lane that yields SCORE_BITS quotient bits, the bank update, and then the lane
// done flag, the pending flag and the output register.
// The next tick is taken once the previous result sits in the output register.
// A stalled output holds its result while the lanes already work on the next tick.
// Reset clears the bank state, the registers to their defaults and all flags.
module dual_bank_holdoff_monitor_unit
    import dbhm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // left_anomaly, left_memory_level, right_anomaly, right_memory_level, dt_us
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // left_score_out, right_score_out, left_recovering, right_recovering,
    // left_holdoff, right_holdoff, any_holdoff, left_time_left_us,
    // right_time_left_us, zero fill
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [OUT_W-1:0] merged;
    logic             accept, load;
    logic             left_done, right_done;
    lane_res_t        left_res, right_res;
    logic             lh, rh;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign load     = pend_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.holdoff_threshold <= HOLDOFF_RST;
            cfg_reg.release_threshold <= RELEASE_RST;
            cfg_reg.rise_tau_us       <= RISE_RST;
            cfg_reg.decay_tau_us      <= DECAY_RST;
            cfg_reg.dwell_us          <= DWELL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLDOFF: cfg_reg.holdoff_threshold <= cfg_data[15:0];
                REG_RELEASE: cfg_reg.release_threshold <= cfg_data[15:0];
                REG_RISE:    cfg_reg.rise_tau_us       <= cfg_data;
                REG_DECAY:   cfg_reg.decay_tau_us      <= cfg_data;
                REG_DWELL:   cfg_reg.dwell_us          <= cfg_data;
                default:     ;
            endcase
        end
    end

    dbhm_lane u_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .anomaly      (s_tdata[15:0]),
        .memory_level (s_tdata[31:16]),
        .dt_us        (s_tdata[79:64]),
        .cfg          (cfg_reg),
        .done         (left_done),
        .res          (left_res)
    );

    dbhm_lane u_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .anomaly      (s_tdata[47:32]),
        .memory_level (s_tdata[63:48]),
        .dt_us        (s_tdata[79:64]),
        .cfg          (cfg_reg),
        .done         (right_done),
        .res          (right_res)
    );

    always_comb
    begin
        lh = left_res.recovering && (left_res.timer != '0);
        rh = right_res.recovering && (right_res.timer != '0);
        merged = {3'b000,
                  24'(right_res.timer),
                  24'(left_res.timer),
                  lh || rh, rh, lh,
                  right_res.recovering, left_res.recovering,
                  16'(right_res.score),
                  16'(left_res.score)};
    end

    always_comb
    begin
        busy_next     = busy_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        if (accept)
            busy_next = 1'b1;
        if (left_done)
            pend_next = 1'b1;
        if (load)
        begin
            pend_next     = 1'b0;
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            m_tdata_reg <= merged;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // Both lanes run the same fixed schedule and must finish together.
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        left_done == right_done)
        else $error("bank lanes finished in different cycles");

    // A lane finishes only while a tick is in flight and no result is pending.
    a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        left_done |-> (busy_reg && !pend_reg))
        else $error("lane finished with no tick in flight");

    // A new result appears only from a pending lane result.
    a_valid_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(pend_reg))
        else $error("output valid without a pending result");

    // The combined holdoff flag agrees with the per-bank flags.
    a_any_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[36] == (m_tdata[34] || m_tdata[35])))
        else $error("any_holdoff disagrees with bank holdoff flags");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the dual-bank holdoff monitor with its own bank predictor.
module tb
    import dbhm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        logic [15:0] l_anom;
        logic [15:0] l_mem;
        logic [15:0] r_anom;
        logic [15:0] r_mem;
        logic [15:0] dt;
    } tick_t;

    typedef struct {
        logic [15:0] l_score;
        logic [15:0] r_score;
        logic        l_rec;
        logic        r_rec;
        logic        l_hold;
        logic        r_hold;
        logic        any_hold;
        logic [23:0] l_time;
        logic [23:0] r_time;
        logic [2:0]  fill;
    } status_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    tick_t   tick_backlog_q[$];
    status_t pending_status_q[$];

    // Predicted register file and bank state, index 0 is the left bank.
    cfg_t                  model_cfg;
    logic [SCORE_BITS-1:0] bank_score [2];
    logic                  bank_rec   [2];
    logic [TIME_BITS-1:0]  bank_timer [2];

    int   err_count = 0;
    int   cycle_cnt = 0;
    logic s_fire    = 1'b0;
    int   send_gap  = 0;
    bit   send_calm = 1'b0;
    int   recv_stall = 0;
    bit   recv_calm = 1'b0;

    dual_bank_holdoff_monitor_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Moves a score toward its target by a rounded fraction dt/tau of the distance.
    function automatic logic [SCORE_BITS-1:0] blend_toward(logic [SCORE_BITS-1:0] prior,
                                                           logic [SCORE_BITS-1:0] target,
                                                           logic [15:0] dt,
                                                           logic [TAU_W-1:0] tau);
        bit [47:0] delta;
        bit [47:0] step;
        if (dt == 0 || tau == 0)
            return prior;
        if (48'(dt) >= 48'(tau))
            return target;
        delta = (target >= prior) ? 48'(target - prior) : 48'(prior - target);
        step = (delta * 48'(dt) + 48'(tau >> 1)) / 48'(tau);
        if (step > delta)
            step = delta;
        return (target >= prior) ? prior + SCORE_BITS'(step) : prior - SCORE_BITS'(step);
    endfunction

    function automatic void advance_bank(int b, logic [15:0] x, logic [15:0] y, logic [15:0] dt);
        logic [SCORE_BITS-1:0] sev;
        sev = (x > y) ? x : y;
        if (sev >= model_cfg.holdoff_threshold)
        begin
            bank_score[b] = blend_toward(bank_score[b], sev, dt, model_cfg.rise_tau_us);
            bank_rec[b]   = 1'b1;
            bank_timer[b] = model_cfg.dwell_us;
        end
        else
        begin
            bank_score[b] = blend_toward(bank_score[b], '0, dt, model_cfg.decay_tau_us);
            // A zero dt leaves an untriggered timer where it is.
            if (dt != 0)
                bank_timer[b] = (bank_timer[b] > dt) ? bank_timer[b] - dt : '0;
            if (bank_timer[b] == 0 && bank_score[b] <= model_cfg.release_threshold)
                bank_rec[b] = 1'b0;
        end
    endfunction

    function automatic status_t step_banks(logic [IN_W-1:0] d);
        status_t s;
        advance_bank(0, d[15:0], d[31:16], d[79:64]);
        advance_bank(1, d[47:32], d[63:48], d[79:64]);
        s.l_score  = bank_score[0];
        s.r_score  = bank_score[1];
        s.l_rec    = bank_rec[0];
        s.r_rec    = bank_rec[1];
        s.l_hold   = bank_rec[0] && bank_timer[0] != 0;
        s.r_hold   = bank_rec[1] && bank_timer[1] != 0;
        s.any_hold = s.l_hold || s.r_hold;
        s.l_time   = bank_timer[0];
        s.r_time   = bank_timer[1];
        s.fill     = '0;
        return s;
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_HOLDOFF: model_cfg.holdoff_threshold = val[15:0];
            REG_RELEASE: model_cfg.release_threshold = val[15:0];
            REG_RISE:    model_cfg.rise_tau_us       = val;
            REG_DECAY:   model_cfg.decay_tau_us      = val;
            REG_DWELL:   model_cfg.dwell_us          = val;
            default: ;
        endcase
    endfunction

    task automatic diff_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_status(logic [OUT_W-1:0] d);
        status_t want;
        if (pending_status_q.size() == 0)
        begin
            $display("%0t ns: unexpected status transfer, expected none, actual %h", $time, d);
            err_count++;
            return;
        end
        want = pending_status_q.pop_front();
        diff_field("left_score_out",     want.l_score,  d[15:0]);
        diff_field("right_score_out",    want.r_score,  d[31:16]);
        diff_field("left_recovering",    want.l_rec,    d[32]);
        diff_field("right_recovering",   want.r_rec,    d[33]);
        diff_field("left_holdoff",       want.l_hold,   d[34]);
        diff_field("right_holdoff",      want.r_hold,   d[35]);
        diff_field("any_holdoff",        want.any_hold, d[36]);
        diff_field("left_time_left_us",  want.l_time,   d[60:37]);
        diff_field("right_time_left_us", want.r_time,   d[84:61]);
        diff_field("zero fill",          want.fill,     d[87:85]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Input transfers are predicted and output transfers checked at the rising edge.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        s_fire    <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                pending_status_q.push_back(step_banks(s_tdata));
            if (m_tvalid && m_tready)
                check_status(m_tdata);
        end
    end

    // Tick driver: holds each tick until its transfer, then waits a random gap.
    always @(negedge clk)
    begin
        if (rst_n && (s_fire || !s_tvalid))
        begin
            if (s_fire)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : pick_gap();
            end
            if (send_gap == 0 && tick_backlog_q.size() != 0)
            begin
                tick_t t;
                t = tick_backlog_q.pop_front();
                s_tdata  <= {t.dt, t.r_mem, t.r_anom, t.l_mem, t.l_anom};
                s_tvalid <= 1'b1;
            end
            else
            begin
                if (send_gap != 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end
        end
    end

    // Status receiver with random stalls.
    always @(negedge clk)
    begin
        if (recv_stall != 0)
        begin
            recv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0)
                recv_calm = !recv_calm;
            if (!recv_calm)
                recv_stall = pick_gap();
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_tick(logic [15:0] la, logic [15:0] lm, logic [15:0] ra,
                              logic [15:0] rm, logic [15:0] dt);
        tick_t t;
        t.l_anom = la;
        t.l_mem  = lm;
        t.r_anom = ra;
        t.r_mem  = rm;
        t.dt     = dt;
        tick_backlog_q.push_back(t);
    endtask

    // Returns once every tick has been sent and every status has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tick_backlog_q.size() != 0 || s_tvalid || pending_status_q.size() != 0);
        @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg(logic [CFG_W-1:0] top, int unsigned typical);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 18)
            return top;
        if (r < 24)
            return CFG_W'($urandom);
        return CFG_W'($urandom_range(1, typical));
    endfunction

    function automatic logic [15:0] pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return 16'($urandom);
        if (r < 20)
            return 16'hFFFF;
        return 16'($urandom_range(1, 20000));
    endfunction

    // One severity above or below the current threshold; the other input is no larger than it.
    task automatic make_pair(bit hot, output logic [15:0] a, output logic [15:0] m);
        logic [15:0] th;
        logic [15:0] sev;
        logic [15:0] other;
        th = model_cfg.holdoff_threshold;
        if (hot || th == 0)
            sev = ($urandom_range(0, 9) == 0) ? th : 16'($urandom_range(16'hFFFF, th));
        else
            sev = ($urandom_range(0, 9) == 0) ? th - 16'd1 : 16'($urandom_range(th - 1, 0));
        other = 16'($urandom_range(sev, 0));
        if ($urandom_range(0, 1))
        begin
            a = sev;
            m = other;
        end
        else
        begin
            a = other;
            m = sev;
        end
    endtask

    // Episodes of triggering ticks followed by quiet ticks, with some pure noise.
    task automatic queue_episodes(int count);
        int    made;
        int    span;
        int    hot_l;
        int    hot_r;
        tick_t t;
        made = 0;
        while (made < count)
        begin
            hot_l = $urandom_range(0, 4);
            hot_r = $urandom_range(0, 4);
            span  = $urandom_range(3, 14);
            for (int i = 0; i < span && made < count; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    t.l_anom = 16'($urandom);
                    t.l_mem  = 16'($urandom);
                    t.r_anom = 16'($urandom);
                    t.r_mem  = 16'($urandom);
                    t.dt     = 16'($urandom);
                end
                else
                begin
                    make_pair(i < hot_l, t.l_anom, t.l_mem);
                    make_pair(i < hot_r, t.r_anom, t.r_mem);
                    t.dt = pick_dt();
                end
                tick_backlog_q.push_back(t);
                made++;
            end
        end
    endtask

    initial
    begin
        model_cfg.holdoff_threshold = HOLDOFF_RST;
        model_cfg.release_threshold = RELEASE_RST;
        model_cfg.rise_tau_us       = RISE_RST;
        model_cfg.decay_tau_us      = DECAY_RST;
        model_cfg.dwell_us          = DWELL_RST;
        for (int b = 0; b < 2; b++)
        begin
            bank_score[b] = '0;
            bank_rec[b]   = 1'b0;
            bank_timer[b] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Defaults: full-scale rise, held ticks, decay to release, threshold boundary.
        queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_tick(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_tick(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0000);
        queue_tick(16'd40000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 8; i++)
            queue_tick(16'h1234, 16'h4321, 16'h0000, 16'h7FFF, 16'hFFFF);
        queue_tick(16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd1000);
        queue_tick(16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001);
        wait_drained();

        // A wide value that masks to a zero threshold, held scores, full dwell, unused indexes.
        write_reg(REG_HOLDOFF, 24'hFF0000);
        write_reg(REG_RISE, '0);
        write_reg(REG_DECAY, '0);
        write_reg(REG_RELEASE, 24'h00FFFF);
        write_reg(REG_DWELL, 24'hFFFFFF);
        write_reg(REG_DWELL + 3'd1, 24'h000001);
        write_reg(REG_DWELL + 3'd2, 24'h123456);
        write_reg(REG_DWELL + 3'd3, 24'hFFFFFF);
        queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        queue_tick(16'hFFFF, 16'h0000, 16'h5A5A, 16'hA5A5, 16'h0001);
        queue_tick(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000);
        wait_drained();

        // Unit time constants, zero dwell and zero release.
        write_reg(REG_HOLDOFF, 24'h00FFFF);
        write_reg(REG_RELEASE, '0);
        write_reg(REG_RISE, 24'd1);
        write_reg(REG_DECAY, 24'd1);
        write_reg(REG_DWELL, '0);
        queue_tick(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFE, 16'h0001);
        queue_tick(16'h0000, 16'hFFFE, 16'h0000, 16'hFFFF, 16'h0000);
        queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        wait_drained();

        // A zero decay constant holds the score on quiet ticks.
        write_reg(REG_HOLDOFF, 24'd40000);
        write_reg(REG_DECAY, '0);
        queue_tick(16'd50000, 16'h0000, 16'h0000, 16'd40000, 16'hFFFF);
        queue_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_HOLDOFF, pick_reg(24'h00FFFF, 65535));
            write_reg(REG_RELEASE, pick_reg(24'h00FFFF, 65535));
            write_reg(REG_RISE, pick_reg(24'hFFFFFF, 120000));
            write_reg(REG_DECAY, pick_reg(24'hFFFFFF, 300000));
            write_reg(REG_DWELL, pick_reg(24'hFFFFFF, 200000));
            if ($urandom_range(0, 1))
                write_reg(REG_DWELL + 3'($urandom_range(1, 3)), CFG_W'($urandom));
            queue_episodes(80);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
